### hw/rtl/ihex_pkg.sv
// Package for the Intel HEX record parser: sizes, status codes, parser state and
// result types, and the hex digit decoder.
// Depends on nothing; used by ihex_step and the top level.
`default_nettype none

package ihex_pkg;

	// Image size in bytes, and the widths that follow from it
	localparam int unsigned IMAGE_DEPTH = 65536;
	localparam int unsigned FILL_W      = $clog2(IMAGE_DEPTH) + 1;
	localparam int unsigned POS_W       = FILL_W + 1;
	localparam int unsigned INDEX_W     = 16;

	// Character codes
	localparam logic [7:0] CHAR_COLON   = 8'h3A;
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

	// Record types that get special handling
	localparam logic [7:0] REC_DATA = 8'h00;
	localparam logic [7:0] REC_EOF  = 8'h01;

	// Saturation limit of the per-line byte counter
	localparam logic [8:0] PAIR_MAX = 9'd511;

	// Result kinds
	localparam logic KIND_DATA   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef enum logic [2:0] {
		ST_DATA_OK   = 3'd0,
		ST_EOF       = 3'd1,
		ST_OTHER_OK  = 3'd2,
		ST_CHECKSUM  = 3'd3,
		ST_FORMAT    = 3'd4,
		ST_OVERFLOW  = 3'd5
	} rec_status_t;

	// Parser state carried from one character to the next
	typedef struct packed {
		logic [8:0]        pair_index;
		logic [3:0]        high_nibble;
		logic              nibble_phase;
		logic              line_started;
		logic [7:0]        running_sum;
		logic [7:0]        rec_len;
		logic [7:0]        type_byte;
		logic [FILL_W-1:0] fill_position;
		logic [15:0]       line_counter;
		logic              halted;
	} parse_state_t;

	// One result item
	typedef struct packed {
		logic              result_kind;
		logic [7:0]        data_byte;
		logic [INDEX_W-1:0] write_index;
		logic [2:0]        record_status;
		logic [7:0]        line_type;
		logic [15:0]       line_number;
	} rec_result_t;

	// Hex digit decode: valid flag in bit 4, value in bits 3:0
	function automatic logic [4:0] hex_nibble(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/ihex_char_if.sv
// Character channel of the Intel HEX parser: valid/ready and one ASCII character.
// Depends on nothing.
`default_nettype none

interface ihex_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;

	modport source (output valid, output char_in, input ready);
	modport sink   (input valid, input char_in, output ready);
endinterface

`default_nettype wire

### hw/rtl/ihex_rec_if.sv
// Result channel of the Intel HEX parser: valid/ready and the result fields.
// Depends on nothing.
`default_nettype none

interface ihex_rec_if;
	logic        valid;
	logic        ready;
	logic        result_kind;
	logic [7:0]  data_byte;
	logic [15:0] write_index;
	logic [2:0]  record_status;
	logic [7:0]  line_type;
	logic [15:0] line_number;

	modport source (output valid, output result_kind, output data_byte, output write_index,
		output record_status, output line_type, output line_number, input ready);
	modport sink   (input valid, input result_kind, input data_byte, input write_index,
		input record_status, input line_type, input line_number, output ready);
endinterface

`default_nettype wire

### hw/rtl/intel_hex_record_parser_core.sv
// Top level of the Intel HEX record parser: input register, step logic, result register.
// Depends on ihex_pkg, ihex_char_if, ihex_rec_if and ihex_step.
`default_nettype none

// Intel HEX record parser. One ASCII character is taken per request on chars; data bytes
// of type-0 records come out on records as soon as they are decoded (result_kind 0), and
// each newline gives one status result (result_kind 1) until the parser stops. A format
// error or a good end-of-file record stops the parser until arst_n is asserted. Throughput
// is one character per clock while the output register does not block: the character is
// registered in the input register, decoded by the step logic and its result registered in
// the output register. The output register blocks the step only while it holds an untaken
// result and the step has a new one; characters that give no result keep flowing.
module intel_hex_record_parser_core
	import ihex_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	ihex_char_if.sink        chars,
	ihex_rec_if.source       records
);

	logic         valid_s1;
	logic [7:0]   char_s1;
	parse_state_t state_q;
	parse_state_t state_nxt;
	logic         res_valid;
	rec_result_t  res;
	logic         out_valid_q;
	rec_result_t  out_q;
	logic         advance;

	ihex_step u_step (
		.char_in   (char_s1),
		.cur       (state_q),
		.nxt       (state_nxt),
		.res_valid (res_valid),
		.res       (res)
	);

	// stage 1 moves on unless its result has nowhere to go
	assign advance      = valid_s1 && (!res_valid || !out_valid_q || records.ready);
	assign chars.ready  = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			char_s1 <= chars.char_in;
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (records.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_q <= res;
		end
	end

	assign records.valid         = out_valid_q;
	assign records.result_kind   = out_q.result_kind;
	assign records.data_byte     = out_q.data_byte;
	assign records.write_index   = out_q.write_index;
	assign records.record_status = out_q.record_status;
	assign records.line_type     = out_q.line_type;
	assign records.line_number   = out_q.line_number;

endmodule

`default_nettype wire

### hw/rtl/ihex_step.sv
// One-character step of the Intel HEX parser: next state and optional result.
// Depends on ihex_pkg.
`default_nettype none

module ihex_step
	import ihex_pkg::*;
(
	input  wire logic [7:0]   char_in,
	input  wire parse_state_t cur,
	output parse_state_t      nxt,
	output logic              res_valid,
	output rec_result_t       res
);

	logic [4:0]       nib;
	logic [7:0]       byte_val;
	logic [8:0]       offset;
	logic [POS_W-1:0] pos;
	logic [POS_W-1:0] fill_end;
	logic             bad_len;

	always_comb begin
		nib      = hex_nibble(char_in);
		byte_val = {cur.high_nibble, nib[3:0]};
		offset   = cur.pair_index - 9'd4;
		pos      = POS_W'(cur.fill_position) + POS_W'(offset);
		fill_end = POS_W'(cur.fill_position) + POS_W'(cur.rec_len);
		bad_len  = cur.nibble_phase || (cur.pair_index < 9'd5)
			|| (cur.pair_index != ({1'b0, cur.rec_len} + 9'd5));

		nxt       = cur;
		res_valid = 1'b0;
		res       = '0;
		res.line_number = cur.line_counter;

		if (cur.halted) begin
			// ignore everything until reset
		end else if (!cur.line_started) begin
			// first character of a line: new line, must be ':'
			nxt.line_counter = cur.line_counter + 16'd1;
			nxt.pair_index   = '0;
			nxt.high_nibble  = '0;
			nxt.nibble_phase = 1'b0;
			nxt.running_sum  = '0;
			nxt.rec_len      = '0;
			nxt.type_byte    = '0;
			res.line_number  = nxt.line_counter;
			if (char_in != CHAR_COLON) begin
				nxt.halted        = 1'b1;
				res_valid         = 1'b1;
				res.result_kind   = KIND_STATUS;
				res.record_status = ST_FORMAT;
			end else begin
				nxt.line_started = 1'b1;
			end
		end else if (char_in == CHAR_NEWLINE) begin
			// end of line: length, checksum and type checks
			nxt.line_started = 1'b0;
			res_valid        = 1'b1;
			res.result_kind  = KIND_STATUS;
			res.line_type    = cur.type_byte;
			if (bad_len) begin
				nxt.halted        = 1'b1;
				res.record_status = ST_FORMAT;
			end else if (cur.running_sum != 8'd0) begin
				res.record_status = ST_CHECKSUM;
			end else if (cur.type_byte == REC_DATA) begin
				if (fill_end > POS_W'(IMAGE_DEPTH)) begin
					res.record_status = ST_OVERFLOW;
				end else begin
					nxt.fill_position = fill_end[FILL_W-1:0];
					res.record_status = ST_DATA_OK;
				end
			end else if (cur.type_byte == REC_EOF) begin
				nxt.halted        = 1'b1;
				res.record_status = ST_EOF;
			end else begin
				res.record_status = ST_OTHER_OK;
			end
		end else if (!nib[4]) begin
			// non-hex character inside a line
			nxt.halted        = 1'b1;
			nxt.line_started  = 1'b0;
			res_valid         = 1'b1;
			res.result_kind   = KIND_STATUS;
			res.record_status = ST_FORMAT;
			res.line_type     = cur.type_byte;
		end else if (!cur.nibble_phase) begin
			nxt.high_nibble  = nib[3:0];
			nxt.nibble_phase = 1'b1;
		end else begin
			// second digit completes a byte
			nxt.nibble_phase = 1'b0;
			nxt.running_sum  = cur.running_sum + byte_val;
			if (cur.pair_index == 9'd0) begin
				nxt.rec_len = byte_val;
			end else if (cur.pair_index == 9'd3) begin
				nxt.type_byte = byte_val;
			end else if (cur.pair_index >= 9'd4 && cur.type_byte == REC_DATA
				&& offset < {1'b0, cur.rec_len}
				&& pos < POS_W'(IMAGE_DEPTH)) begin
				res_valid       = 1'b1;
				res.result_kind = KIND_DATA;
				res.data_byte   = byte_val;
				res.write_index = pos[INDEX_W-1:0];
			end
			if (cur.pair_index < PAIR_MAX) begin
				nxt.pair_index = cur.pair_index + 9'd1;
			end
		end
	end

endmodule

`default_nettype wire
